/* hdl/cws_pkg.sv */
// shared types and constants for the contrast window stretch block
// used by cws_front, cws_queue, cws_back and contrast_window_stretch
`timescale 1ns / 1ps

package cws_pkg;

    localparam int PIX_W = 8;
    localparam int NUM_W = 2 * PIX_W;
    localparam int DIV_STEPS = PIX_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;

    localparam logic KIND_GATHER = 1'b0;
    localparam logic KIND_APPLY = 1'b1;

    localparam logic MODE_MEASURED = 1'b0;
    localparam logic MODE_MANUAL = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_LOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_HIGH = 2'd2;

    // how the back end finishes an apply request
    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_FULL,
        CLS_DIV
    } cls_t;

    typedef struct packed {
        cls_t             cls;
        logic [NUM_W-1:0] num;
        logic [PIX_W-1:0] den;
    } job_t;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] low;
        logic [PIX_W-1:0] high;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

/* hdl/cws_front.sv */
// front end: accepts requests, tracks the gathered range, classifies apply requests
// depends on cws_pkg
`timescale 1ns / 1ps

module cws_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cws_pkg::cfg_t                   cfg,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic                            frame_start,
    input  logic [cws_pkg::PIX_W-1:0]       pixel_in,
    output logic                            push,
    output cws_pkg::job_t                   job,
    input  logic                            q_full
);

    logic [cws_pkg::PIX_W-1:0] min_reg;
    logic [cws_pkg::PIX_W-1:0] min_next;
    logic [cws_pkg::PIX_W-1:0] max_reg;
    logic [cws_pkg::PIX_W-1:0] max_next;
    logic                      any_reg;
    logic                      any_next;

    logic                      accept;
    logic [cws_pkg::PIX_W-1:0] base_min;
    logic [cws_pkg::PIX_W-1:0] base_max;
    logic                      base_any;
    logic [cws_pkg::PIX_W-1:0] lo;
    logic [cws_pkg::PIX_W-1:0] hi;
    logic [cws_pkg::PIX_W-1:0] diff;

    assign in_stall = q_full;
    assign accept = in_valid & ~q_full;
    assign push = accept & (kind == cws_pkg::KIND_APPLY);

    // range tracking
    always_comb
    begin
        base_min = frame_start ? cws_pkg::PIX_MAX : min_reg;
        base_max = frame_start ? cws_pkg::PIX_MIN : max_reg;
        base_any = frame_start ? 1'b0 : any_reg;
        min_next = min_reg;
        max_next = max_reg;
        any_next = any_reg;
        if (accept && kind == cws_pkg::KIND_GATHER)
        begin
            min_next = (pixel_in != cws_pkg::PIX_MAX && pixel_in < base_min) ?
                       pixel_in : base_min;
            max_next = (!base_any || pixel_in > base_max) ? pixel_in : base_max;
            any_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= cws_pkg::PIX_MAX;
            max_reg <= cws_pkg::PIX_MIN;
            any_reg <= 1'b0;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
            any_reg <= any_next;
        end
    end

    // window selection and classification
    always_comb
    begin
        if (cfg.mode == cws_pkg::MODE_MANUAL)
        begin
            lo = cfg.low;
            hi = cfg.high;
        end
        else
        begin
            lo = (min_reg == cws_pkg::PIX_MAX) ? cws_pkg::PIX_MIN : min_reg;
            hi = any_reg ? max_reg : cws_pkg::PIX_MAX;
        end

        diff = pixel_in - lo;
        // (p - lo) * 255 as a shift and subtract
        job.num = {diff, {cws_pkg::PIX_W{1'b0}}} - {{cws_pkg::PIX_W{1'b0}}, diff};
        job.den = hi - lo;

        if (pixel_in < lo)
            job.cls = cws_pkg::CLS_ZERO;
        else if (pixel_in > hi)
            job.cls = cws_pkg::CLS_FULL;
        else if (hi <= lo)
            job.cls = cws_pkg::CLS_ZERO;
        else
            job.cls = cws_pkg::CLS_DIV;
    end

endmodule

/* hdl/cws_queue.sv */
// short queue of classified apply requests between front and back ends
// depends on cws_pkg
`timescale 1ns / 1ps

module cws_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cws_pkg::job_t wr_job,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output cws_pkg::job_t rd_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cws_pkg::job_t slots [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full = (cnt_reg == CNT_W'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign rd_job = slots[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop = pop & q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= wr_job;
    end

endmodule

/* hdl/cws_back.sv */
// back end: one quotient bit per cycle restoring divider and output register
// depends on cws_pkg
`timescale 1ns / 1ps

module cws_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  cws_pkg::job_t             rd_job,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [cws_pkg::PIX_W-1:0] pixel_out
);

    cws_pkg::back_state_t state_reg;
    cws_pkg::back_state_t state_next;

    logic [cws_pkg::PIX_W-1:0]      part_reg;
    logic [cws_pkg::PIX_W-1:0]      part_next;
    logic [cws_pkg::PIX_W-1:0]      shift_reg;
    logic [cws_pkg::PIX_W-1:0]      shift_next;
    logic [cws_pkg::PIX_W-1:0]      den_reg;
    logic [cws_pkg::PIX_W-1:0]      den_next;
    logic [cws_pkg::STEP_CNT_W-1:0] cnt_reg;
    logic [cws_pkg::STEP_CNT_W-1:0] cnt_next;

    logic [cws_pkg::PIX_W:0]        trial;
    logic [cws_pkg::PIX_W:0]        diff;
    logic                           ge;
    logic                           last_step;

    assign last_step = (cnt_reg == cws_pkg::STEP_CNT_W'(cws_pkg::DIV_STEPS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cws_pkg::BK_IDLE:
            begin
                if (q_valid)
                    state_next = (rd_job.cls == cws_pkg::CLS_DIV) ?
                                 cws_pkg::BK_DIV : cws_pkg::BK_OUT;
            end
            cws_pkg::BK_DIV:
            begin
                if (last_step)
                    state_next = cws_pkg::BK_OUT;
            end
            cws_pkg::BK_OUT:
            begin
                if (!out_stall)
                    state_next = cws_pkg::BK_IDLE;
            end
            default:
                state_next = cws_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            cws_pkg::BK_IDLE: pop = q_valid;
            cws_pkg::BK_OUT:  out_valid = 1'b1;
            default:
            begin
                pop = 1'b0;
                out_valid = 1'b0;
            end
        endcase
    end

    assign pixel_out = shift_reg;

    // datapath: partial remainder in part_reg, dividend bits shift out of
    // shift_reg while quotient bits shift in
    always_comb
    begin
        trial = {part_reg, shift_reg[cws_pkg::PIX_W-1]};
        diff = trial - {1'b0, den_reg};
        ge = (trial >= {1'b0, den_reg});
        part_next = part_reg;
        shift_next = shift_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        if (state_reg == cws_pkg::BK_IDLE && q_valid)
        begin
            den_next = rd_job.den;
            cnt_next = '0;
            part_next = rd_job.num[cws_pkg::NUM_W-1:cws_pkg::PIX_W];
            case (rd_job.cls)
                cws_pkg::CLS_DIV:  shift_next = rd_job.num[cws_pkg::PIX_W-1:0];
                cws_pkg::CLS_FULL: shift_next = cws_pkg::PIX_MAX;
                default:           shift_next = cws_pkg::PIX_MIN;
            endcase
        end
        else if (state_reg == cws_pkg::BK_DIV)
        begin
            // quotient stays below 256, so the remainder fits in 8 bits
            part_next = ge ? diff[cws_pkg::PIX_W-1:0] : trial[cws_pkg::PIX_W-1:0];
            shift_next = {shift_reg[cws_pkg::PIX_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cws_pkg::BK_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        shift_reg <= shift_next;
        den_reg <= den_next;
    end

endmodule

/* hdl/contrast_window_stretch.sv */
// top level of the contrast window stretch block: configuration registers,
// front end, request queue and divider back end
// depends on cws_pkg, cws_front, cws_queue, cws_back
`timescale 1ns / 1ps

// usage
// - input channel (in_valid / in_stall): kind 0 gathers pixel_in into the
//   measured range (frame_start clears it first), kind 1 asks for a stretched
//   pixel. gather requests give no result.
// - output channel (out_valid / out_stall): one pixel_out per apply request,
//   in order.
// - config channel (cfg_valid / cfg_ready, always ready): index 0 mode,
//   1 manual low, 2 manual high; index 3 is ignored. write only while idle.
// - a gather request is taken whenever in_stall is low. an apply request is
//   classified combinationally in the front end and queued when taken; the
//   back end pops it, then goes to the output state for a clamped pixel, or
//   runs 8 steps of the bit-serial divider first for an in-window pixel. the
//   output state holds while out_stall is high, and the back end pops the
//   next request only after the last result has left the output register.
// - a stalled result holds in the output register; the queue keeps taking
//   requests until it is full, then in_stall rises.
// - reset: mode measured, window 0..255, measured range empty, queue empty.

module contrast_window_stretch
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic       frame_start,
    input  logic [7:0] pixel_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] pixel_out
);

    cws_pkg::cfg_t cfg_reg;
    cws_pkg::cfg_t cfg_next;
    cws_pkg::job_t wr_job;
    cws_pkg::job_t rd_job;
    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                cws_pkg::REG_MODE:        cfg_next.mode = cfg_data[0];
                cws_pkg::REG_MANUAL_LOW:  cfg_next.low = cfg_data;
                cws_pkg::REG_MANUAL_HIGH: cfg_next.high = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode <= cws_pkg::MODE_MEASURED;
            cfg_reg.low <= cws_pkg::PIX_MIN;
            cfg_reg.high <= cws_pkg::PIX_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cws_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .frame_start (frame_start),
        .pixel_in    (pixel_in),
        .push        (push),
        .job         (wr_job),
        .q_full      (q_full)
    );

    cws_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_job  (wr_job),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .rd_job  (rd_job)
    );

    cws_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .rd_job    (rd_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out)
    );

endmodule
